// File: rtl/rsv_pkg.sv
// Shared types, constants and functions of the surface-of-revolution vertex block.
package rsv_pkg;

  // Field widths
  localparam int SLICE_W = 10;
  localparam int POINT_W = 10;
  localparam int COORD_W = 16;
  localparam int CFG_W   = 11;
  localparam int ADDR_W  = 20;
  localparam int PHASE_W = 16;

  // Register limits and reset values
  localparam logic [CFG_W-1:0] MAX_SLICES         = 11'd1024;
  localparam logic [CFG_W-1:0] MAX_PROFILE_POINTS = 11'd1024;
  localparam logic [CFG_W-1:0] SLICE_COUNT_RST    = 11'd16;
  localparam logic [CFG_W-1:0] PROFILE_POINTS_RST = 11'd16;

  // Default depth of the full-turn sine table (power of two)
  localparam int TRIG_DEPTH_DEF = 1024;

  // pi in Q30, used only when the sine table is built
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Phase divider: quotient bits are resolved in equal slices per stage
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = PHASE_W / DIV_STAGES;

  // Stages from input transaction to output register
  localparam int PIPE_DEPTH = DIV_STAGES + 4;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SLICE_COUNT    = 1'b0,
    REG_PROFILE_POINTS = 1'b1
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Item fields that ride alongside the phase and trig stages
  typedef struct packed {
    logic [SLICE_W-1:0] slice;
    logic [POINT_W-1:0] point;
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic               err;
  } side_t;

  // One finished vertex
  typedef struct packed {
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic [ADDR_W-1:0]  addr;
    logic               err;
  } result_t;

  // Rounded Q15 sine magnitude of an angle in Q30 radians (0 to pi/2),
  // by a Taylor series up to the 21st power. Evaluated at elaboration.
  function automatic logic [14:0] quarter_sine_q15(input logic [63:0] ang);
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] q15;
    t   = ang;
    pos = ang;
    neg = 64'd0;
    t = ((((t * ang) >> 30) * ang) >> 30) / 64'd6;   neg = neg + t;
    t = ((((t * ang) >> 30) * ang) >> 30) / 64'd20;  pos = pos + t;
    t = ((((t * ang) >> 30) * ang) >> 30) / 64'd42;  neg = neg + t;
    t = ((((t * ang) >> 30) * ang) >> 30) / 64'd72;  pos = pos + t;
    t = ((((t * ang) >> 30) * ang) >> 30) / 64'd110; neg = neg + t;
    t = ((((t * ang) >> 30) * ang) >> 30) / 64'd156; pos = pos + t;
    t = ((((t * ang) >> 30) * ang) >> 30) / 64'd210; neg = neg + t;
    t = ((((t * ang) >> 30) * ang) >> 30) / 64'd272; pos = pos + t;
    t = ((((t * ang) >> 30) * ang) >> 30) / 64'd342; neg = neg + t;
    t = ((((t * ang) >> 30) * ang) >> 30) / 64'd420; pos = pos + t;
    if (neg >= pos) begin
      q15 = 64'd0;
    end else begin
      q15 = ((pos - neg) + 64'd16384) >> 15;
    end
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    return q15[14:0];
  endfunction

  // Floor shift by 15 and saturate to 16 bits signed
  function automatic coord_t shift_sat(input logic signed [32:0] acc);
    coord_t r;
    if (acc[32:30] == 3'b000 || acc[32:30] == 3'b111) begin
      r = acc[30:15];
    end else if (acc[32]) begin
      r = 16'sh8000;
    end else begin
      r = 16'sh7fff;
    end
    return r;
  endfunction

endpackage

// File: rtl/rsv_phase_div.sv
// Pipelined restoring divider giving the turn fraction floor(slice * 65536 / slices).
module rsv_phase_div import rsv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SLICE_W-1:0] in_slice,
  input  logic [CFG_W-1:0]   divisor,
  input  side_t              in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PHASE_W-1:0] out_phase,
  output side_t              out_side
);

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES-1:0] adv;
  logic [DIV_STAGES-1:0] vld_src;
  logic [CFG_W-1:0]      rem       [DIV_STAGES];
  logic [CFG_W-1:0]      rem_src   [DIV_STAGES];
  logic [CFG_W-1:0]      rem_next  [DIV_STAGES];
  logic [PHASE_W-1:0]    quo       [DIV_STAGES];
  logic [PHASE_W-1:0]    quo_src   [DIV_STAGES];
  logic [PHASE_W-1:0]    quo_next  [DIV_STAGES];
  side_t                 side      [DIV_STAGES];
  side_t                 side_src  [DIV_STAGES];

  // A stage advances when it is empty or the one after it advances
  always_comb begin
    adv[DIV_STAGES-1] = !vld[DIV_STAGES-1] || out_ready;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  // Stage inputs: the transaction for the first stage, the previous stage otherwise
  always_comb begin
    vld_src[0]  = in_valid;
    rem_src[0]  = CFG_W'(in_slice);
    quo_src[0]  = '0;
    side_src[0] = in_side;
    for (int k = 1; k < DIV_STAGES; k++) begin
      vld_src[k]  = vld[k-1];
      rem_src[k]  = rem[k-1];
      quo_src[k]  = quo[k-1];
      side_src[k] = side[k-1];
    end
  end

  // Resolve DIV_STEPS quotient bits per stage; an in-range slice index is already
  // below the divisor, so only zeros are shifted in
  always_comb begin
    logic [CFG_W-1:0]   r;
    logic [PHASE_W-1:0] q;
    logic [CFG_W:0]     t;
    for (int k = 0; k < DIV_STAGES; k++) begin
      r = rem_src[k];
      q = quo_src[k];
      for (int b = 0; b < DIV_STEPS; b++) begin
        t = {r, 1'b0};
        if (t >= {1'b0, divisor}) begin
          t = t - {1'b0, divisor};
          q = {q[PHASE_W-2:0], 1'b1};
        end else begin
          q = {q[PHASE_W-2:0], 1'b0};
        end
        r = t[CFG_W-1:0];
      end
      rem_next[k] = r;
      quo_next[k] = q;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld_src[k];
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (adv[k]) begin
        rem[k]  <= rem_next[k];
        quo[k]  <= quo_next[k];
        side[k] <= side_src[k];
      end
    end
  end

  assign out_valid = vld[DIV_STAGES-1];
  assign out_phase = quo[DIV_STAGES-1];
  assign out_side  = side[DIV_STAGES-1];

endmodule

// File: rtl/rsv_trig.sv
// Table index from the turn fraction, then sine and cosine from a quarter-wave table.
module rsv_trig import rsv_pkg::*; #(
  parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PHASE_W-1:0] in_phase,
  input  side_t              in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output coord_t             out_sin,
  output coord_t             out_cos,
  output side_t              out_side
);

  localparam int IDX_W   = $clog2(TRIG_TABLE_DEPTH);
  localparam int QUARTER = TRIG_TABLE_DEPTH / 4;
  localparam int QA_W    = IDX_W - 1;

  logic [14:0]       qtab [QUARTER+1];
  logic [1:0]        vld;
  logic [1:0]        adv;
  logic [PHASE_W+IDX_W:0] rnd;
  logic [IDX_W-1:0]  idx_s;
  logic [IDX_W-1:0]  idx_c;
  logic [IDX_W-1:0]  ia   [2];
  coord_t            val  [2];
  side_t             side0;
  coord_t            sin1;
  coord_t            cos1;
  side_t             side1;

  // Quarter-wave sine magnitudes, fixed at elaboration
  for (genvar k = 0; k <= QUARTER; k++) begin : g_tab
    localparam logic [63:0] ANG =
      (64'(k) * 64'd2 * PI_Q30 + 64'(TRIG_TABLE_DEPTH / 2)) / 64'(TRIG_TABLE_DEPTH);
    assign qtab[k] = quarter_sine_q15(ANG);
  end

  // Ready chain over the two stages
  assign adv[1]   = !vld[1] || out_ready;
  assign adv[0]   = !vld[0] || adv[1];
  assign in_ready = adv[0];

  // Round the fraction to the table grid; wrap past a full turn
  assign rnd = {1'b0, in_phase, {IDX_W{1'b0}}} + (PHASE_W + IDX_W + 1)'(32768);

  // Fold each index into the first quadrant and restore the sign
  always_comb begin
    logic [QA_W-1:0] a;
    logic [14:0]     mag;
    ia[0] = idx_s;
    ia[1] = idx_c;
    for (int l = 0; l < 2; l++) begin
      a = {1'b0, ia[l][IDX_W-3:0]};
      if (ia[l][IDX_W-2]) begin
        a = QA_W'(QUARTER) - a;
      end
      mag = qtab[a];
      if (ia[l][IDX_W-1]) begin
        val[l] = -$signed({1'b0, mag});
      end else begin
        val[l] = $signed({1'b0, mag});
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      if (adv[1]) begin
        vld[1] <= vld[0];
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      idx_s <= rnd[PHASE_W+IDX_W-1:PHASE_W];
      idx_c <= rnd[PHASE_W+IDX_W-1:PHASE_W] + IDX_W'(QUARTER);
      side0 <= in_side;
    end
    if (adv[1]) begin
      sin1  <= val[0];
      cos1  <= val[1];
      side1 <= side0;
    end
  end

  assign out_valid = vld[1];
  assign out_sin   = sin1;
  assign out_cos   = cos1;
  assign out_side  = side1;

endmodule

// File: rtl/rsv_rotate.sv
// Rotation products, saturating sums and vertex address, ending in the output register.
module rsv_rotate import rsv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  coord_t           in_sin,
  input  coord_t           in_cos,
  input  side_t            in_side,
  input  logic [CFG_W-1:0] profile_points,
  output logic             out_valid,
  input  logic             out_ready,
  output result_t          out_res
);

  logic [1:0]                 vld;
  logic [1:0]                 adv;
  logic signed [31:0]         p_cx;
  logic signed [31:0]         p_sz;
  logic signed [31:0]         p_sx;
  logic signed [31:0]         p_cz;
  logic [SLICE_W+CFG_W-1:0]   addr_prod;
  side_t                      side0;
  logic signed [32:0]         acc_x;
  logic signed [32:0]         acc_z;
  result_t                    res_next;
  result_t                    res;

  // Ready chain; the second stage is the output register
  assign adv[1]   = !vld[1] || out_ready;
  assign adv[0]   = !vld[0] || adv[1];
  assign in_ready = adv[0];

  // Sum the products; zero everything on an index error
  always_comb begin
    acc_x = 33'(p_cx) + 33'(p_sz);
    acc_z = 33'(p_cz) - 33'(p_sx);
    if (side0.err) begin
      res_next     = '0;
      res_next.err = 1'b1;
    end else begin
      res_next.x    = shift_sat(acc_x);
      res_next.y    = side0.y;
      res_next.z    = shift_sat(acc_z);
      res_next.addr = ADDR_W'(addr_prod + (SLICE_W + CFG_W)'(side0.point));
      res_next.err  = 1'b0;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= in_valid;
      end
      if (adv[1]) begin
        vld[1] <= vld[0];
      end
    end
  end

  // Products, then the finished vertex
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      p_cx      <= in_cos * in_side.x;
      p_sz      <= in_sin * in_side.z;
      p_sx      <= in_sin * in_side.x;
      p_cz      <= in_cos * in_side.z;
      addr_prod <= in_side.slice * profile_points;
      side0     <= in_side;
    end
    if (adv[1]) begin
      res <= res_next;
    end
  end

  assign out_valid = vld[1];
  assign out_res   = res;

endmodule

// File: rtl/revolution_surface_vertex.sv
// Top level of the surface-of-revolution vertex generator.
//
// Turns one profile point about the Y axis by 2*pi*slice/slice_count and
// returns the rotated vertex with its flat address slice*profile_points+point.
// Input stream s_axis: one profile point per transaction. Output stream m_axis:
// one vertex per input transaction, in order; m_axis_tuser flags an index out
// of range, in which case all data fields are zero.
// Configuration: cfg_index selects slice_count (0) or profile_points (1);
// cfg_data is the value, clamped to 1024. Write only while no item is in flight.
// Pipeline: the four-stage phase divider, the two-stage table lookup and the
// multiply/sum stages. Throughput: one item per cycle unless the output stalls.
// Each stage advances whenever it is empty or the stage after it moves, so
// bubbles close up while the output is stalled. When m_axis_tready is low the
// result stays in the output register and the stages fill behind it;
// s_axis_tready drops once all eight hold an item.
// Reset clears all valid bits and returns both registers to 16.
module revolution_surface_vertex import rsv_pkg::*; #(
  parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // Input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // slice_index[9:0], point_index[19:10], profile_x[35:20], profile_y[51:36],
  // profile_z[67:52], zero[71:68]
  input  logic [71:0]      s_axis_tdata,
  // Output stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // vertex_x[15:0], vertex_y[31:16], vertex_z[47:32], vertex_address[67:48],
  // zero[71:68]
  output logic [71:0]      m_axis_tdata,
  // index_error[0]
  output logic [0:0]       m_axis_tuser
);

  logic [CFG_W-1:0]   slice_count;
  logic [CFG_W-1:0]   profile_points;
  logic [CFG_W-1:0]   cfg_clamped;
  side_t              in_side;
  logic               div_valid;
  logic               div_ready;
  logic [PHASE_W-1:0] div_phase;
  side_t              div_side;
  logic               trig_valid;
  logic               trig_ready;
  coord_t             trig_sin;
  coord_t             trig_cos;
  side_t              trig_side;
  result_t            res;

  // Configuration: always ready, clamp to the maximum
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_clamped = cfg_data;
    unique case (cfg_index)
      REG_SLICE_COUNT: begin
        if (cfg_data > MAX_SLICES) begin
          cfg_clamped = MAX_SLICES;
        end
      end
      REG_PROFILE_POINTS: begin
        if (cfg_data > MAX_PROFILE_POINTS) begin
          cfg_clamped = MAX_PROFILE_POINTS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_count    <= SLICE_COUNT_RST;
      profile_points <= PROFILE_POINTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLICE_COUNT:    slice_count    <= cfg_clamped;
        REG_PROFILE_POINTS: profile_points <= cfg_clamped;
      endcase
    end
  end

  // Unpack the input transaction and check both indexes
  always_comb begin
    in_side.slice = s_axis_tdata[9:0];
    in_side.point = s_axis_tdata[19:10];
    in_side.x     = s_axis_tdata[35:20];
    in_side.y     = s_axis_tdata[51:36];
    in_side.z     = s_axis_tdata[67:52];
    in_side.err   = (CFG_W'(in_side.slice) >= slice_count) ||
                    (CFG_W'(in_side.point) >= profile_points);
  end

  rsv_phase_div u_phase_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_slice  (s_axis_tdata[9:0]),
    .divisor   (slice_count),
    .in_side   (in_side),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_phase (div_phase),
    .out_side  (div_side)
  );

  rsv_trig #(
    .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
  ) u_trig (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_valid),
    .in_ready  (div_ready),
    .in_phase  (div_phase),
    .in_side   (div_side),
    .out_valid (trig_valid),
    .out_ready (trig_ready),
    .out_sin   (trig_sin),
    .out_cos   (trig_cos),
    .out_side  (trig_side)
  );

  rsv_rotate u_rotate (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (trig_valid),
    .in_ready       (trig_ready),
    .in_sin         (trig_sin),
    .in_cos         (trig_cos),
    .in_side        (trig_side),
    .profile_points (profile_points),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_res        (res)
  );

  // Pack the output transaction
  assign m_axis_tdata = {4'b0000, res.addr, res.z, res.y, res.x};
  assign m_axis_tuser = res.err;

endmodule

// File: rtl/rsv_checker.sv
// Port-level checks on the vertex block, bound to its top level.
module rsv_checker import rsv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [71:0] m_axis_tdata,
  input  logic [0:0]  m_axis_tuser
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

  logic [CNT_W-1:0] pending;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Track items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // No result without an outstanding item
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    pending == '0 |-> !m_axis_tvalid)
    else $error("result with no item outstanding");

  // Never more items in flight than pipeline stages
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than stages");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output transaction changed");

  // An index error carries all-zero data
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("index error with non-zero data");

endmodule

bind revolution_surface_vertex rsv_checker u_rsv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
